>>> hdl/assert_macros.svh
// Assertion macros shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define QRTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define QRTT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/qrtt_pkg.sv
// Shared types and codes for the query retry/timeout tracker.
`timescale 1ns / 1ps
`default_nettype none

package qrtt_pkg;

  localparam int TARGETS_DEF = 16;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  // Item opcodes
  localparam logic [1:0] OP_POLL  = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_RESP  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Target kinds
  localparam logic [1:0] KIND_SERVER = 2'd0;
  localparam logic [1:0] KIND_MASTER = 2'd1;
  localparam logic [1:0] KIND_BCAST  = 2'd2;

  // Slot status
  localparam logic [1:0] ST_QUEUED    = 2'd0;
  localparam logic [1:0] ST_QUERIED   = 2'd1;
  localparam logic [1:0] ST_RESPONDED = 2'd2;
  localparam logic [1:0] ST_NORESP    = 2'd3;

  // Result events
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_SEND_SERVER = 3'd1;
  localparam logic [2:0] EV_SEND_BCAST  = 3'd2;
  localparam logic [2:0] EV_SEND_MASTER = 3'd3;
  localparam logic [2:0] EV_RESPONDER   = 3'd4;
  localparam logic [2:0] EV_FULL        = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_SEND_SPACING  = 2'd0;
  localparam logic [1:0] REG_REPLY_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd2;

  localparam logic [15:0] SEND_SPACING_RST  = 16'd50;
  localparam logic [15:0] REPLY_TIMEOUT_RST = 16'd2000;
  localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd3;
  localparam logic [7:0]  ATTEMPT_MAX       = 8'd255;

  typedef struct packed {
    logic [15:0] addr;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] sent;
    logic [7:0]  attempts;
  } entry_t;

  // Verdict of the slot evaluator on one table entry
  typedef struct packed {
    logic   wr;
    logic   take;
    logic   notdone;
    logic   addr_hit;
    logic   zero_hit;
    entry_t entry;
  } slot_eval_t;

endpackage

`default_nettype wire

>>> hdl/qrtt_slot_eval.sv
// Per-slot evaluator: timeout marking, send pick, lookup hits, completion.
`timescale 1ns / 1ps
`default_nettype none

module qrtt_slot_eval (
  input  qrtt_pkg::entry_t     entry,
  input  logic                 is_poll,
  input  logic                 send_allowed,
  input  logic [15:0]          addr_in,
  input  logic [31:0]          now,
  input  logic [31:0]          elapsed,
  input  logic [15:0]          reply_timeout,
  input  logic [7:0]           retry_limit,
  output qrtt_pkg::slot_eval_t result
);

  import qrtt_pkg::*;

  logic       timed;
  logic       mark;
  logic       cand;
  logic       take;
  logic [1:0] upd;

  always_comb begin
    timed = elapsed > {16'd0, reply_timeout};
    // retries used up and reply overdue: give up on it
    mark  = is_poll && (entry.status == ST_QUERIED) &&
            (entry.attempts >= retry_limit) && timed;
    upd   = mark ? ST_NORESP : entry.status;
    cand  = (upd == ST_QUEUED) || ((upd == ST_QUERIED) && timed);
    take  = is_poll && send_allowed && cand;

    result.entry = entry;
    if (mark) begin
      result.entry.status = ST_NORESP;
    end
    if (take) begin
      result.entry.status = ST_QUERIED;
      result.entry.sent   = now;
      if (entry.attempts != ATTEMPT_MAX) begin
        result.entry.attempts = entry.attempts + 8'd1;
      end
    end

    result.wr       = mark || take;
    result.take     = take;
    result.notdone  = take || (upd == ST_QUEUED) || (upd == ST_QUERIED);
    result.addr_hit = (entry.addr == addr_in);
    result.zero_hit = (entry.addr == 16'd0);
  end

endmodule

`default_nettype wire

>>> hdl/query_retry_timeout_tracker.sv
// Top level of the query retry/timeout tracker: slot table, sequencer, ports.
//
//   Channel   Dir  Handshake          Contents
//   s_*       in   tvalid/tready      tuser opcode; tdata addr, kind, now, ok
//   m_*       out  tvalid/tready      tuser event; tdata index, addr, ping, done
//   cfg_*     in   cfg_we only        register index and write data
//
// One item at a time. The result is loaded after a set-up cycle, one scan of the
// slot table through the single memory read port, one slot per cycle, and a
// closing cycle; a clear goes straight from set-up to closing. s_tready returns
// with the result, so the next item is taken only once this one's result is loaded.
// rst is synchronous: the table is emptied, registers take their reset values.
// A result waiting on m_tready does not stop the next item's scan; only its
// closing cycle waits until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module query_retry_timeout_tracker #(
  parameter int TARGETS = qrtt_pkg::TARGETS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // slave side
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [15:0] addr_id, [17:16] target_kind, [49:18] now_ms, [50] response_ok
  input  logic [qrtt_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [1:0] opcode
  input  logic [1:0]                       s_tuser,
  // master side
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [3:0] entry_index, [19:4] out_addr_id, [51:20] ping_ms, [52] all_done
  output logic [qrtt_pkg::OUT_TDATA_W-1:0] m_tdata,
  // [2:0] event_res
  output logic [2:0]                       m_tuser,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [15:0]                      cfg_data
);

  import qrtt_pkg::*;

  localparam int IW = (TARGETS > 1) ? $clog2(TARGETS) : 1;  // slot index
  localparam int CW = $clog2(TARGETS + 1);                  // slot count

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_SCAN, S_FINISH} state_t;

  state_t      state;

  // configuration
  logic [15:0] spacing_ms;
  logic [15:0] reply_window;
  logic [7:0]  retry_lim;

  // table bookkeeping
  logic [CW-1:0] entry_count;
  logic [31:0]   last_send;

  // item being worked on
  logic [1:0]  op_r;
  logic [15:0] addr_r;
  logic [1:0]  kind_r;
  logic [31:0] now_r;
  logic        ok_r;
  logic [1:0]  kind_in;

  // scan state
  logic          spacing_ok;
  logic [CW-1:0] issue_idx;
  logic          pend_valid;
  logic [IW-1:0] pend_idx;
  logic [CW-1:0] notdone_cnt;
  logic          send_found;
  logic [IW-1:0] send_idx;
  logic [1:0]    send_kind;
  logic [15:0]   send_addr;
  logic          s_found;
  logic [IW-1:0] s_idx;
  entry_t        s_entry;
  logic          b_found;
  logic [1:0]    b_status;
  logic [31:0]   b_sent;

  // result register
  logic [2:0]  ev_out;
  logic [3:0]  idx_out;
  logic [15:0] oaddr_out;
  logic [31:0] ping_out;
  logic        done_out;

  // slot table
  entry_t        table_mem [TARGETS];
  entry_t        rd_data;
  logic          rd_en;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  entry_t        mem_wd;

  // shared subtractor
  logic [31:0] sub_b;
  logic [31:0] elapsed;

  slot_eval_t  ev;

  // closing cycle
  logic          out_free;
  logic          fin;
  logic          fin_we;
  logic [IW-1:0] fin_wa;
  entry_t        fin_wd;
  logic          cnt_inc;
  logic          cnt_clr;
  logic [2:0]    ev_next;
  logic [IW-1:0] idx_next;
  logic [15:0]   oaddr_next;
  logic [31:0]   ping_next;
  logic          done_next;
  logic          s_nd;
  logic          done_adj;
  logic          room;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {3'b000, done_out, ping_out, oaddr_out, idx_out};
  assign m_tuser  = ev_out;

  assign kind_in  = (s_tdata[17:16] > KIND_BCAST) ? KIND_SERVER : s_tdata[17:16];
  assign out_free = !m_tvalid || m_tready;
  assign fin      = (state == S_FINISH) && out_free;

  assign rd_en = ((state == S_PREP) || (state == S_SCAN)) && (op_r != OP_CLEAR) &&
                 (issue_idx < entry_count);

  // one subtractor: spacing check, per-slot age, then round-trip time
  always_comb begin
    case (state)
      S_PREP:  sub_b = last_send;
      S_SCAN:  sub_b = rd_data.sent;
      default: sub_b = s_found ? s_entry.sent : b_sent;
    endcase
  end
  assign elapsed = now_r - sub_b;

  qrtt_slot_eval u_eval (
    .entry         (rd_data),
    .is_poll       (op_r == OP_POLL),
    .send_allowed  (spacing_ok && !send_found),
    .addr_in       (addr_r),
    .now           (now_r),
    .elapsed       (elapsed),
    .reply_timeout (reply_window),
    .retry_limit   (retry_lim),
    .result        (ev)
  );

  // closing decision per opcode
  always_comb begin
    fin_we     = 1'b0;
    fin_wa     = s_idx;
    fin_wd     = s_entry;
    cnt_inc    = 1'b0;
    cnt_clr    = 1'b0;
    ev_next    = EV_NONE;
    idx_next   = '0;
    oaddr_next = 16'd0;
    ping_next  = 32'd0;
    s_nd       = (s_entry.status == ST_QUEUED) || (s_entry.status == ST_QUERIED);
    // table complete once the matched slot is marked responded
    done_adj   = (notdone_cnt == CW'(s_nd));
    done_next  = (notdone_cnt == '0);
    room       = (entry_count < CW'(TARGETS));
    case (op_r)
      OP_POLL: begin
        if (send_found) begin
          case (send_kind)
            KIND_BCAST:  ev_next = EV_SEND_BCAST;
            KIND_MASTER: ev_next = EV_SEND_MASTER;
            default:     ev_next = EV_SEND_SERVER;
          endcase
          idx_next   = send_idx;
          oaddr_next = send_addr;
        end
      end
      OP_ADD: begin
        if (s_found) begin
          fin_we      = 1'b1;
          fin_wd.kind = kind_r;
        end else if (room) begin
          fin_we    = 1'b1;
          fin_wa    = entry_count[IW-1:0];
          fin_wd    = '{addr: addr_r, kind: kind_r, status: ST_QUEUED,
                        sent: 32'd0, attempts: 8'd0};
          cnt_inc   = 1'b1;
          done_next = 1'b0;
        end else begin
          ev_next    = EV_FULL;
          oaddr_next = addr_r;
        end
      end
      OP_RESP: begin
        if (s_found && (s_entry.kind == KIND_MASTER)) begin
          // master replies are only noted
          if (ok_r) begin
            fin_we        = 1'b1;
            fin_wd.status = ST_RESPONDED;
            done_next     = done_adj;
          end
        end else if (ok_r) begin
          if (!s_found) begin
            // unknown responder: adopt it while the broadcast is out
            if (b_found && (b_status == ST_QUERIED)) begin
              if (!room) begin
                ev_next    = EV_FULL;
                oaddr_next = addr_r;
              end else begin
                fin_we     = 1'b1;
                fin_wa     = entry_count[IW-1:0];
                fin_wd     = '{addr: addr_r, kind: KIND_SERVER, status: ST_RESPONDED,
                               sent: b_sent, attempts: 8'd0};
                cnt_inc    = 1'b1;
                ev_next    = EV_RESPONDER;
                idx_next   = entry_count[IW-1:0];
                oaddr_next = addr_r;
                ping_next  = elapsed;
              end
            end
          end else if (s_entry.status != ST_RESPONDED) begin
            fin_we        = 1'b1;
            fin_wd.status = ST_RESPONDED;
            ev_next       = EV_RESPONDER;
            idx_next      = s_idx;
            oaddr_next    = s_entry.addr;
            ping_next     = elapsed;
            done_next     = done_adj;
          end
        end
      end
      default: begin
        cnt_clr   = 1'b1;
        done_next = 1'b1;
      end
    endcase
  end

  // single write port: scan updates, else the closing write
  always_comb begin
    if (state == S_SCAN) begin
      mem_we = pend_valid && ev.wr;
      mem_wa = pend_idx;
      mem_wd = ev.entry;
    end else begin
      mem_we = fin && fin_we;
      mem_wa = fin_wa;
      mem_wd = fin_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_wa] <= mem_wd;
    end
    rd_data <= table_mem[issue_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      entry_count  <= '0;
      last_send    <= 32'd0;
      spacing_ms   <= SEND_SPACING_RST;
      reply_window <= REPLY_TIMEOUT_RST;
      retry_lim    <= RETRY_LIMIT_RST;
      pend_valid   <= 1'b0;
      issue_idx    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SEND_SPACING:  spacing_ms   <= cfg_data;
          REG_REPLY_TIMEOUT: reply_window <= cfg_data;
          REG_RETRY_LIMIT:   retry_lim    <= cfg_data[7:0];
          default: ;
        endcase
      end

      // result register: loaded by the closing cycle, freed by its transfer
      if (fin) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      // read issue: one slot a cycle
      pend_valid <= rd_en;
      pend_idx   <= issue_idx[IW-1:0];
      if (rd_en) begin
        issue_idx <= issue_idx + CW'(1);
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_r      <= s_tuser;
            addr_r    <= s_tdata[15:0];
            kind_r    <= kind_in;
            now_r     <= s_tdata[49:18];
            ok_r      <= s_tdata[50];
            issue_idx <= '0;
            state     <= S_PREP;
          end
        end
        S_PREP: begin
          spacing_ok  <= (elapsed >= {16'd0, spacing_ms});
          notdone_cnt <= '0;
          send_found  <= 1'b0;
          s_found     <= 1'b0;
          b_found     <= 1'b0;
          state       <= (op_r == OP_CLEAR) ? S_FINISH : S_SCAN;
        end
        S_SCAN: begin
          if (pend_valid) begin
            if (ev.notdone) begin
              notdone_cnt <= notdone_cnt + CW'(1);
            end
            if (ev.take) begin
              send_found <= 1'b1;
              send_idx   <= pend_idx;
              send_kind  <= rd_data.kind;
              send_addr  <= rd_data.addr;
              last_send  <= now_r;
            end
            if (ev.addr_hit && !s_found) begin
              s_found <= 1'b1;
              s_idx   <= pend_idx;
              s_entry <= rd_data;
            end
            if (ev.zero_hit && !b_found) begin
              b_found  <= 1'b1;
              b_status <= rd_data.status;
              b_sent   <= rd_data.sent;
            end
          end
          if (!rd_en) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            ev_out    <= ev_next;
            idx_out   <= 4'(idx_next);
            oaddr_out <= oaddr_next;
            ping_out  <= ping_next;
            done_out  <= done_next;
            if (cnt_clr) begin
              entry_count <= '0;
            end else if (cnt_inc) begin
              entry_count <= entry_count + CW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `QRTT_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid && state == S_IDLE, "reset left work pending")
  `QRTT_ASSERT(a_count_bound, entry_count <= CW'(TARGETS), "slot count beyond table depth")
  `QRTT_ASSERT(a_send_stamp, fin && op_r == OP_POLL && send_found |-> last_send == now_r, "send without time stamp")
  `QRTT_ASSERT(a_clear_empties, fin && op_r == OP_CLEAR |=> entry_count == '0, "clear left slots")

endmodule

`default_nettype wire
